/* rtl/core/nlat_pkg.sv */
// nlat_pkg: shared types, codes and index math for the node/link adjacency table.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package nlat_pkg;

    localparam int ID_W         = 6;
    localparam int CNT_W        = 7;
    localparam int ENT_W        = 7;
    localparam int TRI_IDX_W    = 12;
    localparam int KIND_DEPTH   = 1 << ID_W;
    localparam int MAX_DESC_DEF = 64;

    localparam logic [ENT_W-1:0] NONE_MARK = 7'd127;
    localparam logic KIND_NODE = 1'b0;
    localparam logic KIND_LINK = 1'b1;

    typedef enum logic [2:0] {
        OP_ADD_NODE = 3'd0,
        OP_ADD_LINK = 3'd1,
        OP_LIST     = 3'd2,
        OP_BETWEEN  = 3'd3,
        OP_KIND     = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOT_NODE = 3'd3,
        ST_SELF     = 3'd4,
        ST_NONE_ADJ = 3'd5,
        ST_NOT_CONN = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_BKIND,
        S_MARK,
        S_FIN_A,
        S_FIN_B,
        S_FIN_C,
        S_LIST,
        S_LEND,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]      opcode;
        logic [ID_W-1:0] first_id;
        logic [ID_W-1:0] second_id;
    } req_beat_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] result_id;
        logic            kind;
        logic            last;
    } rsp_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]  rd_a;
        logic [ID_W-1:0]  rd_b;
        logic             wr_en;
        logic [ID_W-1:0]  wr_a;
        logic [ID_W-1:0]  wr_b;
        logic [ENT_W-1:0] wr_data;
        logic [ID_W-1:0]  krd0;
        logic [ID_W-1:0]  krd1;
        logic             kwr_en;
        logic [ID_W-1:0]  kwr_addr;
        logic             kwr_kind;
    } store_req_t;

    typedef struct packed {
        logic [ENT_W-1:0] tri_data;
        logic             kind0;
        logic             kind1;
        logic             busy;
    } store_rsp_t;

    function automatic logic [TRI_IDX_W-1:0] tri_index(input logic [ID_W-1:0] a,
                                                       input logic [ID_W-1:0] b);
        logic [ID_W-1:0]      g;
        logic [ID_W-1:0]      l;
        logic [TRI_IDX_W-1:0] prod;
        g    = (a > b) ? a : b;
        l    = (a > b) ? b : a;
        prod = TRI_IDX_W'(g) * (TRI_IDX_W'(g) + TRI_IDX_W'(1));
        return (prod >> 1) + TRI_IDX_W'(l);
    endfunction

endpackage

/* rtl/core/nlat_store.sv */
// nlat_store: triangle memory and kind memory, registered reads.
// Runs the post-reset clearing sweep of the triangle memory. Depends on nlat_pkg.
`timescale 1ns / 1ps

module nlat_store #(
    parameter int MAX_DESCRIPTORS = nlat_pkg::MAX_DESC_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nlat_pkg::store_req_t req,
    output nlat_pkg::store_rsp_t rsp
);
    import nlat_pkg::*;

    localparam int DEPTH = MAX_DESCRIPTORS * (MAX_DESCRIPTORS + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [TRI_IDX_W-1:0] DEPTH_L = TRI_IDX_W'(DEPTH);
    localparam logic [AW-1:0]        LAST_L  = AW'(DEPTH - 1);

    logic [ENT_W-1:0] tri_mem [DEPTH];
    logic             kind_mem [KIND_DEPTH];

    logic             clr_busy_reg, clr_busy_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [ENT_W-1:0] rd_data_reg;
    logic             kind0_reg, kind1_reg;

    logic [TRI_IDX_W-1:0] rd_ix, wr_ix;
    logic [AW-1:0]        rd_addr, wr_addr, mem_waddr;
    logic [ENT_W-1:0]     mem_wdata;
    logic                 mem_we;

    assign rd_ix   = tri_index(req.rd_a, req.rd_b);
    assign wr_ix   = tri_index(req.wr_a, req.wr_b);
    assign rd_addr = (rd_ix < DEPTH_L) ? rd_ix[AW-1:0] : '0;
    assign wr_addr = (wr_ix < DEPTH_L) ? wr_ix[AW-1:0] : '0;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_L)
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    assign mem_we    = clr_busy_reg | req.wr_en;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_busy_reg ? NONE_MARK : req.wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tri_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tri_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.kwr_en)
        begin
            kind_mem[req.kwr_addr] <= req.kwr_kind;
        end
        kind0_reg <= kind_mem[req.krd0];
        kind1_reg <= kind_mem[req.krd1];
    end

    assign rsp.tri_data = rd_data_reg;
    assign rsp.kind0    = kind0_reg;
    assign rsp.kind1    = kind1_reg;
    assign rsp.busy     = clr_busy_reg;

endmodule

/* rtl/core/nlat_seq.sv */
// nlat_seq: request sequencer; checks, scans rows of the store and issues result beats.
// Depends on nlat_pkg; drives nlat_store through store_req_t.
`timescale 1ns / 1ps

module nlat_seq #(
    parameter int MAX_DESCRIPTORS = nlat_pkg::MAX_DESC_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  nlat_pkg::req_beat_t  in_beat,
    output nlat_pkg::store_req_t sreq,
    input  nlat_pkg::store_rsp_t srsp,
    output logic                 push,
    output nlat_pkg::rsp_beat_t  push_beat,
    input  logic                 out_free
);
    import nlat_pkg::*;

    localparam logic [CNT_W-1:0] MAX_L = CNT_W'(MAX_DESCRIPTORS);

    state_t          state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [ID_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ENT_W-1:0] v_reg, v_next;
    logic            mark_b_reg, mark_b_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [ID_W-1:0] pend_idx_reg, pend_idx_next;
    logic            held_valid_reg, held_valid_next;
    logic [ID_W-1:0] held_idx_reg, held_idx_next;
    logic            opp_reg, opp_next;
    rsp_beat_t       res_reg, res_next;

    logic            accept, issue, scan_done, data_hit;
    logic [ID_W-1:0] scan_node;
    logic            mark_hit, list_hit, list_replay;
    logic            a_out, b_out, full;
    logic            look_err;
    status_t         look_status;

    function automatic rsp_beat_t err_beat(input status_t st);
        rsp_beat_t r;
        r.status    = st;
        r.result_id = '0;
        r.kind      = KIND_NODE;
        r.last      = 1'b1;
        return r;
    endfunction

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || srsp.busy;
    assign scan_node = mark_b_reg ? b_reg : a_reg;
    assign issue     = idx_reg < cnt_reg;
    assign scan_done = !issue && !pend_reg;
    assign data_hit  = srsp.tri_data != NONE_MARK;
    assign mark_hit  = pend_reg && (pend_idx_reg != scan_node)
                       && (pend_idx_reg != v_reg[ID_W-1:0]) && data_hit
                       && (srsp.kind0 == KIND_LINK);
    assign list_hit  = pend_reg && (pend_idx_reg != a_reg) && data_hit
                       && (srsp.kind0 == opp_reg);
    assign list_replay = list_hit && held_valid_reg && !out_free;
    assign a_out     = {1'b0, a_reg} >= cnt_reg;
    assign b_out     = {1'b0, b_reg} >= cnt_reg;
    assign full      = cnt_reg >= MAX_L;

    always_comb
    begin
        look_err    = 1'b0;
        look_status = ST_OK;
        unique case (op_reg)
            OP_ADD_NODE:
            begin
                look_err    = full;
                look_status = ST_FULL;
            end
            OP_ADD_LINK:
            begin
                look_err = 1'b1;
                if (a_out || b_out)
                    look_status = ST_RANGE;
                else if (srsp.kind0 != KIND_NODE || srsp.kind1 != KIND_NODE)
                    look_status = ST_NOT_NODE;
                else if (a_reg == b_reg)
                    look_status = ST_SELF;
                else if (full)
                    look_status = ST_FULL;
                else
                    look_err = 1'b0;
            end
            OP_LIST, OP_KIND:
            begin
                look_err    = a_out;
                look_status = ST_RANGE;
            end
            OP_BETWEEN:
            begin
                look_err = 1'b1;
                if (a_out || b_out)
                    look_status = ST_RANGE;
                else if (!data_hit)
                    look_status = ST_NOT_CONN;
                else
                    look_err = 1'b0;
            end
            default:
            begin
                look_err    = 1'b0;
                look_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_beat.opcode)
                        OP_ADD_NODE, OP_ADD_LINK, OP_LIST, OP_BETWEEN, OP_KIND:
                            state_next = S_LOOK;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOK:
            begin
                if (look_err)
                    state_next = S_RESP;
                else
                begin
                    case (op_reg)
                        OP_ADD_LINK: state_next = S_MARK;
                        OP_LIST:     state_next = S_LIST;
                        OP_BETWEEN:  state_next = S_BKIND;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_BKIND: state_next = S_RESP;
            S_MARK:
            begin
                if (scan_done && mark_b_reg)
                    state_next = S_FIN_A;
            end
            S_FIN_A: state_next = S_FIN_B;
            S_FIN_B: state_next = S_FIN_C;
            S_FIN_C: state_next = S_RESP;
            S_LIST:
            begin
                if (scan_done)
                    state_next = S_LEND;
            end
            S_LEND:
            begin
                if (!held_valid_reg)
                    state_next = S_RESP;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        cnt_next        = cnt_reg;
        v_next          = v_reg;
        mark_b_next     = mark_b_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        opp_next        = opp_reg;
        res_next        = res_reg;
        sreq            = '0;
        push            = 1'b0;
        push_beat       = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                sreq.rd_a = in_beat.first_id;
                sreq.rd_b = in_beat.second_id;
                sreq.krd0 = in_beat.first_id;
                sreq.krd1 = in_beat.second_id;
                if (accept)
                begin
                    op_next = in_beat.opcode;
                    a_next  = in_beat.first_id;
                    b_next  = in_beat.second_id;
                end
            end
            S_LOOK:
            begin
                sreq.krd0 = srsp.tri_data[ID_W-1:0];
                if (look_err)
                    res_next = err_beat(look_status);
                else
                begin
                    case (op_reg)
                        OP_ADD_NODE, OP_ADD_LINK:
                        begin
                            v_next        = cnt_reg;
                            cnt_next      = cnt_reg + CNT_W'(1);
                            sreq.wr_en    = 1'b1;
                            sreq.wr_a     = cnt_reg[ID_W-1:0];
                            sreq.wr_b     = cnt_reg[ID_W-1:0];
                            sreq.kwr_en   = 1'b1;
                            sreq.kwr_addr = cnt_reg[ID_W-1:0];
                            if (op_reg == OP_ADD_NODE)
                            begin
                                sreq.wr_data  = ENT_W'(KIND_NODE);
                                sreq.kwr_kind = KIND_NODE;
                            end
                            else
                            begin
                                sreq.wr_data  = ENT_W'(KIND_LINK);
                                sreq.kwr_kind = KIND_LINK;
                            end
                            res_next.status    = ST_OK;
                            res_next.result_id = cnt_reg[ID_W-1:0];
                            res_next.kind      = (op_reg == OP_ADD_NODE) ? KIND_NODE
                                                                         : KIND_LINK;
                            res_next.last      = 1'b1;
                            mark_b_next = 1'b0;
                            idx_next    = '0;
                            pend_next   = 1'b0;
                        end
                        OP_LIST:
                        begin
                            opp_next        = ~srsp.kind0;
                            idx_next        = '0;
                            pend_next       = 1'b0;
                            held_valid_next = 1'b0;
                        end
                        OP_BETWEEN:
                        begin
                            v_next = srsp.tri_data;
                        end
                        default:
                        begin
                            res_next.status    = ST_OK;
                            res_next.result_id = a_reg;
                            res_next.kind      = srsp.kind0;
                            res_next.last      = 1'b1;
                        end
                    endcase
                end
            end
            S_BKIND:
            begin
                res_next.status    = ST_OK;
                res_next.result_id = v_reg[ID_W-1:0];
                res_next.kind      = (v_reg < cnt_reg) ? srsp.kind0 : KIND_NODE;
                res_next.last      = 1'b1;
            end
            S_MARK:
            begin
                sreq.rd_a    = scan_node;
                sreq.rd_b    = idx_reg[ID_W-1:0];
                sreq.krd0    = idx_reg[ID_W-1:0];
                sreq.wr_en   = mark_hit;
                sreq.wr_a    = v_reg[ID_W-1:0];
                sreq.wr_b    = pend_idx_reg;
                sreq.wr_data = {1'b0, scan_node};
                pend_next     = issue;
                pend_idx_next = idx_reg[ID_W-1:0];
                if (issue)
                    idx_next = idx_reg + CNT_W'(1);
                if (scan_done && !mark_b_reg)
                begin
                    mark_b_next = 1'b1;
                    idx_next    = '0;
                end
            end
            S_FIN_A:
            begin
                sreq.wr_en   = 1'b1;
                sreq.wr_a    = v_reg[ID_W-1:0];
                sreq.wr_b    = a_reg;
                sreq.wr_data = {1'b0, b_reg};
            end
            S_FIN_B:
            begin
                sreq.wr_en   = 1'b1;
                sreq.wr_a    = v_reg[ID_W-1:0];
                sreq.wr_b    = b_reg;
                sreq.wr_data = {1'b0, a_reg};
            end
            S_FIN_C:
            begin
                sreq.wr_en   = 1'b1;
                sreq.wr_a    = a_reg;
                sreq.wr_b    = b_reg;
                sreq.wr_data = v_reg;
            end
            S_LIST:
            begin
                sreq.rd_a = a_reg;
                sreq.rd_b = idx_reg[ID_W-1:0];
                sreq.krd0 = idx_reg[ID_W-1:0];
                if (list_replay)
                begin
                    idx_next  = {1'b0, pend_idx_reg};
                    pend_next = 1'b0;
                end
                else
                begin
                    pend_next     = issue;
                    pend_idx_next = idx_reg[ID_W-1:0];
                    if (issue)
                        idx_next = idx_reg + CNT_W'(1);
                    if (list_hit)
                    begin
                        if (held_valid_reg)
                        begin
                            push                = 1'b1;
                            push_beat.status    = ST_OK;
                            push_beat.result_id = held_idx_reg;
                            push_beat.kind      = opp_reg;
                            push_beat.last      = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_idx_next   = pend_idx_reg;
                    end
                end
            end
            S_LEND:
            begin
                if (held_valid_reg)
                begin
                    push                = out_free;
                    push_beat.status    = ST_OK;
                    push_beat.result_id = held_idx_reg;
                    push_beat.kind      = opp_reg;
                    push_beat.last      = 1'b1;
                end
                else
                begin
                    res_next = err_beat(ST_NONE_ADJ);
                end
            end
            S_RESP:
            begin
                push = out_free;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            mark_b_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            mark_b_reg     <= mark_b_next;
            pend_reg       <= pend_next;
            held_valid_reg <= held_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        v_reg        <= v_next;
        pend_idx_reg <= pend_idx_next;
        held_idx_reg <= held_idx_next;
        opp_reg      <= opp_next;
        res_reg      <= res_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_L)
        else $error("descriptor count beyond limit");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("beat pushed into a full output register");

    a_mark_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK && sreq.wr_en) |-> (sreq.wr_a == v_reg[ID_W-1:0]))
        else $error("sharing mark written outside the new link row");

    a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && state_reg == S_LIST) |-> !push_beat.last)
        else $error("last flag set before the adjacency scan ended");

endmodule

/* rtl/core/node_link_adjacency_table.sv */
// node_link_adjacency_table: top level; output register and sequencer/store wiring.
// Depends on nlat_pkg, nlat_store and nlat_seq.
`timescale 1ns / 1ps

// Graph table of nodes and links sharing one descriptor numbering. After reset the
// block clears its triangle memory, one entry a cycle, all of its
// MAX_DESCRIPTORS*(MAX_DESCRIPTORS+1)/2 entries, and holds req_stall high meanwhile.
// One request is in flight at a time. Add link walks the rows of both ends through
// the single read port of the triangle memory. List adjacent walks one row and can
// be held by an output stall. The output register lets a beat wait while the next
// request is taken.
module node_link_adjacency_table #(
    parameter int MAX_DESCRIPTORS = nlat_pkg::MAX_DESC_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  nlat_pkg::req_beat_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output nlat_pkg::rsp_beat_t rsp
);
    import nlat_pkg::*;

    store_req_t sreq;
    store_rsp_t srsp;
    logic       push;
    rsp_beat_t  push_beat;
    logic       out_free;
    logic       out_valid_reg, out_valid_next;
    rsp_beat_t  out_beat_reg, out_beat_next;

    assign out_free = !out_valid_reg || !rsp_stall;

    nlat_store #(
        .MAX_DESCRIPTORS(MAX_DESCRIPTORS)
    ) u_store (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (sreq),
        .rsp  (srsp)
    );

    nlat_seq #(
        .MAX_DESCRIPTORS(MAX_DESCRIPTORS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_valid),
        .in_stall (req_stall),
        .in_beat  (req),
        .sreq     (sreq),
        .srsp     (srsp),
        .push     (push),
        .push_beat(push_beat),
        .out_free (out_free)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_beat_next  = push_beat;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_beat_reg;

endmodule

/* test/nlat_checker.sv */
// nlat_checker: watches both channels of node_link_adjacency_table, predicts every
// response beat from its own copy of the triangle store and compares them in order.
// Depends on nlat_pkg.
`timescale 1ns / 1ps

module nlat_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  nlat_pkg::req_beat_t req,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  nlat_pkg::rsp_beat_t rsp,
    output int                  fail_count,
    output int                  outstanding,
    output int                  used_ids,
    output int                  beats_checked
);
    import nlat_pkg::*;

    localparam int MAX_IDS = MAX_DESC_DEF;
    localparam int DEPTH   = MAX_IDS * (MAX_IDS + 1) / 2;

    logic [ENT_W-1:0] tri_mem [0:DEPTH-1];
    int               desc_count;
    rsp_beat_t        expected_q [$];

    function automatic int pair_index(input int a, input int b);
        int g;
        int l;
        g = (a > b) ? a : b;
        l = (a > b) ? b : a;
        return g * (g + 1) / 2 + l;
    endfunction

    function automatic logic kind_at(input int d);
        return tri_mem[pair_index(d, d)][0];
    endfunction

    task automatic push_beat(input status_t st, input int id, input logic k, input logic l);
        rsp_beat_t b;
        b.status    = st;
        b.result_id = id[ID_W-1:0];
        b.kind      = k;
        b.last      = l;
        expected_q.insert(expected_q.size(), b);
    endtask

    task automatic share_node(input int link, input int node);
        for (int i = 0; i < desc_count; i++)
        begin
            if (i != node && i != link && tri_mem[pair_index(node, i)] != NONE_MARK
                && kind_at(i) == KIND_LINK)
                tri_mem[pair_index(link, i)] = ENT_W'(node);
        end
    endtask

    task automatic predict_request(input req_beat_t r);
        int   a;
        int   b;
        int   v;
        int   n;
        logic opp;
        a = r.first_id;
        b = r.second_id;
        case (r.opcode)
            OP_ADD_NODE:
            begin
                if (desc_count >= MAX_IDS)
                    push_beat(ST_FULL, 0, 1'b0, 1'b1);
                else
                begin
                    v = desc_count;
                    desc_count++;
                    tri_mem[pair_index(v, v)] = ENT_W'(KIND_NODE);
                    push_beat(ST_OK, v, KIND_NODE, 1'b1);
                end
            end
            OP_ADD_LINK:
            begin
                if (a >= desc_count || b >= desc_count)
                    push_beat(ST_RANGE, 0, 1'b0, 1'b1);
                else if (kind_at(a) != KIND_NODE || kind_at(b) != KIND_NODE)
                    push_beat(ST_NOT_NODE, 0, 1'b0, 1'b1);
                else if (a == b)
                    push_beat(ST_SELF, 0, 1'b0, 1'b1);
                else if (desc_count >= MAX_IDS)
                    push_beat(ST_FULL, 0, 1'b0, 1'b1);
                else
                begin
                    v = desc_count;
                    desc_count++;
                    tri_mem[pair_index(v, v)] = ENT_W'(KIND_LINK);
                    share_node(v, a);
                    share_node(v, b);
                    tri_mem[pair_index(v, a)] = ENT_W'(b);
                    tri_mem[pair_index(v, b)] = ENT_W'(a);
                    tri_mem[pair_index(a, b)] = ENT_W'(v);
                    push_beat(ST_OK, v, KIND_LINK, 1'b1);
                end
            end
            OP_LIST:
            begin
                if (a >= desc_count)
                    push_beat(ST_RANGE, 0, 1'b0, 1'b1);
                else
                begin
                    opp = (kind_at(a) == KIND_NODE) ? KIND_LINK : KIND_NODE;
                    n   = 0;
                    for (int i = 0; i < desc_count; i++)
                    begin
                        if (i != a && tri_mem[pair_index(a, i)] != NONE_MARK
                            && kind_at(i) == opp)
                        begin
                            push_beat(ST_OK, i, opp, 1'b0);
                            n++;
                        end
                    end
                    if (n == 0)
                        push_beat(ST_NONE_ADJ, 0, 1'b0, 1'b1);
                    else
                        expected_q[expected_q.size() - 1].last = 1'b1;
                end
            end
            OP_BETWEEN:
            begin
                if (a >= desc_count || b >= desc_count)
                    push_beat(ST_RANGE, 0, 1'b0, 1'b1);
                else
                begin
                    v = tri_mem[pair_index(a, b)];
                    if (v == NONE_MARK)
                        push_beat(ST_NOT_CONN, 0, 1'b0, 1'b1);
                    else
                        push_beat(ST_OK, v, (v < desc_count) ? kind_at(v) : 1'b0, 1'b1);
                end
            end
            OP_KIND:
            begin
                if (a >= desc_count)
                    push_beat(ST_RANGE, 0, 1'b0, 1'b1);
                else
                    push_beat(ST_OK, a, kind_at(a), 1'b1);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                tri_mem[i] = NONE_MARK;
            desc_count    = 0;
            expected_q.delete();
            fail_count    = 0;
            beats_checked = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                beats_checked++;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected beat: status %0d result_id %0d", rsp.status,
                           rsp.result_id);
                    fail_count++;
                end
                else
                begin
                    rsp_beat_t e;
                    e = expected_q.pop_front();
                    if (rsp.status != e.status)
                    begin
                        $error("status expected %0d got %0d", e.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.result_id != e.result_id)
                    begin
                        $error("result_id expected %0d got %0d", e.result_id, rsp.result_id);
                        fail_count++;
                    end
                    if (rsp.kind != e.kind)
                    begin
                        $error("kind expected %0d got %0d", e.kind, rsp.kind);
                        fail_count++;
                    end
                    if (rsp.last != e.last)
                    begin
                        $error("last expected %0d got %0d", e.last, rsp.last);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                predict_request(req);
        end
        outstanding = expected_q.size();
        used_ids    = desc_count;
    end

endmodule

/* test/tb_node_link_adjacency_table.sv */
// tb_node_link_adjacency_table: drives directed and random requests into the
// adjacency table with random idling on both sides; nlat_checker does the checking.
// Depends on nlat_pkg, nlat_checker and the node_link_adjacency_table RTL.
`timescale 1ns / 1ps

module tb_node_link_adjacency_table;
    import nlat_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_beat_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_beat_t rsp;

    int fail_count;
    int outstanding;
    int used_ids;
    int beats_checked;
    int items_sent;
    int hold_cycles;
    bit quiet;

    node_link_adjacency_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    nlat_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .used_ids      (used_ids),
        .beats_checked (beats_checked)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #(12 * 2_000_000);
        $display("** node_link_adjacency_table: FAILED **");
        $finish;
    end

    // receiver: random stall bursts, long hold-off on request
    initial
    begin
        int burst;
        burst     = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_stall = 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                rsp_stall = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                burst     = $urandom_range(1, 7) - 1;
                rsp_stall = 1'b1;
            end
            else
                rsp_stall = 1'b0;
        end
    end

    task automatic send(input logic [2:0] op, input int a, input int b);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req_valid     = 1'b1;
        req.opcode    = op;
        req.first_id  = a[ID_W-1:0];
        req.second_id = b[ID_W-1:0];
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        req_valid = 1'b0;
        items_sent++;
    endtask

    function automatic int pick_id();
        if (used_ids > 0 && $urandom_range(0, 9) < 8)
            return $urandom_range(0, used_ids - 1);
        return $urandom_range(0, 63);
    endfunction

    initial
    begin
        int r;
        logic [2:0] op;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        hold_cycles = 0;
        quiet       = 1'b0;
        items_sent  = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        send(OP_KIND, 0, 0);
        send(OP_LIST, 0, 0);
        send(OP_BETWEEN, 0, 0);
        send(OP_ADD_LINK, 0, 1);
        send(OP_ADD_NODE, 63, 63);
        send(OP_ADD_NODE, 0, 0);
        send(OP_ADD_NODE, 0, 0);
        send(OP_LIST, 0, 0);
        send(OP_ADD_LINK, 0, 1);
        send(OP_ADD_LINK, 2, 1);
        send(OP_ADD_LINK, 1, 0);
        send(OP_ADD_LINK, 3, 0);
        send(OP_ADD_LINK, 1, 1);
        send(OP_ADD_LINK, 0, 63);
        send(OP_LIST, 1, 0);
        send(OP_LIST, 3, 0);
        send(OP_BETWEEN, 0, 1);
        send(OP_BETWEEN, 3, 3);
        send(OP_BETWEEN, 0, 2);
        send(OP_BETWEEN, 3, 5);
        send(OP_KIND, 4, 0);
        send(3'd5, 63, 0);
        send(3'd6, 0, 63);
        send(3'd7, 42, 21);

        // drain before random traffic
        wait (outstanding == 0);
        repeat (150) @(negedge clk);

        for (int n = 0; n < 125; n++)
        begin
            if (n == 40)
                hold_cycles = 300;
            if (n == 100)
                quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 22)
                op = OP_ADD_NODE;
            else if (r < 50)
                op = OP_ADD_LINK;
            else if (r < 68)
                op = OP_LIST;
            else if (r < 82)
                op = OP_BETWEEN;
            else if (r < 94)
                op = OP_KIND;
            else
                op = 3'($urandom_range(5, 7));
            send(op, pick_id(), pick_id());
        end
        // close with one add of each kind and a list
        send(OP_ADD_NODE, 0, 0);
        send(OP_ADD_LINK, 0, 1);
        send(OP_LIST, 0, 0);

        wait (outstanding == 0);
        repeat (200) @(negedge clk);
        $display("Sent %0d requests, checked %0d response beats, %0d descriptors in use.",
                 items_sent, beats_checked, used_ids);
        if (fail_count == 0)
            $display("** node_link_adjacency_table: PASSED **");
        else
            $display("** node_link_adjacency_table: FAILED **");
        $finish;
    end

endmodule
